// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion helpers
// Clocked property checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLKD(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/ppfm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppfm_pkg - pulse period flow meter package
// Field widths, codes, register defaults and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfm_pkg;

  localparam int CHANNELS_DEF = 12;

  localparam int KIND_W  = 2;
  localparam int CHAN_W  = 4;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 4;
  localparam int FLOW_W  = 32;
  localparam int TICK_W  = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_CONSTANT = 1'b1;

  localparam logic [TICK_W-1:0] TIMEOUT_LIMIT_RST = 8'd20;
  localparam logic [FLOW_W-1:0] FLOW_CONSTANT_RST = 32'd19393939;

  localparam logic [TICK_W-1:0] TICK_SAT  = '1;
  localparam logic [FLOW_W-1:0] FLOW_SAT  = '1;

  // job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_ARM  = 2'd0,
    KIND_EDGE = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EC_WAIT_FIRST  = 2'd0,
    EC_WAIT_SECOND = 2'd1,
    EC_DONE        = 2'd2
  } edge_state_t;

  typedef struct packed {
    logic [STAMP_W-1:0] first_stamp;
    edge_state_t        ec;
    logic [TICK_W-1:0]  ticks;
  } chan_state_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [STAMP_W-1:0] period;
    logic               timed_out;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_EVAL
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/ppfm_in_if.sv =====
// ----------------------------------------------------------------------------
// ppfm_in_if - item channel
// Valid/ready channel carrying arm, edge and tick items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppfm_in_if
  import ppfm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CHAN_W-1:0]  channel;
  logic [STAMP_W-1:0] timestamp;

  modport source (output valid, output kind, output channel, output timestamp,
                  input ready);
  modport sink   (input valid, input kind, input channel, input timestamp,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ppfm_out_if.sv =====
// ----------------------------------------------------------------------------
// ppfm_out_if - result channel
// Valid/ready channel carrying period and flow results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppfm_out_if
  import ppfm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot;
  logic [STAMP_W-1:0] period;
  logic [FLOW_W-1:0]  flow;
  logic               timed_out;

  modport source (output valid, output slot, output period, output flow,
                  output timed_out, input ready);
  modport sink   (input valid, input slot, input period, input flow,
                  input timed_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/ppfm_ram.sv =====
// ----------------------------------------------------------------------------
// ppfm_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppfm_front.sv =====
// ----------------------------------------------------------------------------
// ppfm_front - item classifier
// Read-modify-write of per-channel state; queues period and timeout jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfm_front
  import ppfm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int HALF    = (CHANNELS + 1) / 2
) (
  input  logic              clk,
  input  logic              rst,
  ppfm_in_if.sink           item,
  input  logic [TICK_W-1:0] timeout_limit,
  output job_t              job,
  output logic              push,
  input  logic              full
);

  front_state_t state, state_next;

  logic [KIND_W-1:0]  cur_kind;
  logic [AW-1:0]      cur_chan;
  logic [SLOT_W-1:0]  cur_slot;
  logic [STAMP_W-1:0] cur_ts;
  logic [CHANNELS-1:0] seen;

  logic        accept, item_ok, rd_en, wr_en, need_job;
  logic [31:0] slot_calc;
  chan_state_t rd_word, cs, ns;

  assign item.ready = (state == F_IDLE);
  assign accept     = item.valid && item.ready;
  assign item_ok    = (32'(item.channel) < CHANNELS) &&
                      ((item.kind == KIND_ARM) || (item.kind == KIND_EDGE) ||
                       (item.kind == KIND_TICK));
  assign rd_en      = accept && item_ok;

  // even channel c -> c/2, odd channel c -> HALF + (c-1)/2
  assign slot_calc = item.channel[0] ? (32'(HALF) + 32'(item.channel >> 1))
                                     : 32'(item.channel >> 1);

  ppfm_ram #(
    .WIDTH ($bits(chan_state_t)),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cur_chan),
    .wdata (ns),
    .re    (rd_en),
    .raddr (AW'(item.channel)),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_kind <= item.kind;
      cur_chan <= AW'(item.channel);
      cur_slot <= slot_calc[SLOT_W-1:0];
      cur_ts   <= item.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      seen  <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        seen[cur_chan] <= 1'b1;
      end
    end
  end

  always_comb begin
    // a channel never written reads as freshly armed
    cs = seen[cur_chan] ? rd_word : '0;
    ns = cs;
    need_job      = 1'b0;
    job.slot      = cur_slot;
    job.period    = '0;
    job.timed_out = 1'b0;
    case (kind_t'(cur_kind))
      KIND_ARM: begin
        ns.ec    = EC_WAIT_FIRST;
        ns.ticks = '0;
      end
      KIND_EDGE: begin
        if (cs.ec == EC_WAIT_FIRST) begin
          ns.first_stamp = cur_ts;
          ns.ec          = EC_WAIT_SECOND;
        end else if (cs.ec == EC_WAIT_SECOND) begin
          need_job   = 1'b1;
          job.period = cur_ts - cs.first_stamp;
          ns.ec      = EC_DONE;
        end
      end
      KIND_TICK: begin
        if ((cs.ec == EC_WAIT_FIRST) || (cs.ec == EC_WAIT_SECOND)) begin
          if ((cs.ticks > timeout_limit) || (cs.ticks == TICK_SAT)) begin
            need_job      = 1'b1;
            job.timed_out = 1'b1;
            ns.ec         = EC_DONE;
          end else begin
            ns.ticks = cs.ticks + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    push       = 1'b0;
    case (state)
      F_IDLE: begin
        if (rd_en) begin
          state_next = F_EVAL;
        end
      end
      F_EVAL: begin
        // hold the write until the job fits in the queue
        if (!(need_job && full)) begin
          wr_en      = 1'b1;
          push       = need_job;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ppfm_queue.sv =====
// ----------------------------------------------------------------------------
// ppfm_queue - job FIFO
// Short FIFO decoupling the classifier from the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfm_queue
  import ppfm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic avail
);

  job_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign avail   = (count != '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppfm_back.sv =====
// ----------------------------------------------------------------------------
// ppfm_back - flow divider and result stage
// Restoring divider, one quotient bit per cycle, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ppfm_back
  import ppfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  job_t              q_job,
  output logic              pop,
  input  logic [FLOW_W-1:0] flow_constant,
  ppfm_out_if.source        result
);

  localparam int CNT_W = $clog2(FLOW_W);

  back_state_t state, state_next;

  job_t               cur;
  logic [FLOW_W-1:0]  quo, divisor, rem;
  logic [CNT_W-1:0]   cnt;
  logic [FLOW_W:0]    trial;

  logic               res_valid;
  job_t               res_job;
  logic [FLOW_W-1:0]  res_flow;
  logic               load_out, start_div;

  assign trial = {rem, quo[FLOW_W-1]} - {1'b0, divisor};

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    start_div  = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          if (q_job.timed_out || (q_job.period == '0)) begin
            state_next = B_OUT;
          end else begin
            start_div  = 1'b1;
            state_next = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (cnt == CNT_W'(FLOW_W - 1)) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (!res_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= q_job;
      divisor <= q_job.period;
      rem     <= '0;
      cnt     <= '0;
      if (q_job.timed_out) begin
        quo <= '0;
      end else if (q_job.period == '0) begin
        quo <= FLOW_SAT;
      end else begin
        quo <= flow_constant;
      end
    end else if (state == B_DIV) begin
      cnt <= cnt + 1'b1;
      if (!trial[FLOW_W]) begin
        rem <= trial[FLOW_W-1:0];
        quo <= {quo[FLOW_W-2:0], 1'b1};
      end else begin
        rem <= {rem[FLOW_W-2:0], quo[FLOW_W-1]};
        quo <= {quo[FLOW_W-2:0], 1'b0};
      end
    end
    if (load_out) begin
      res_job  <= cur;
      res_flow <= quo;
    end
  end

  assign result.valid     = res_valid;
  assign result.slot      = res_job.slot;
  assign result.period    = res_job.period;
  assign result.timed_out = res_job.timed_out;
  assign result.flow      = res_flow;

  `ASSERT_CLKD(a_div_nonzero, clk, rst, (state == B_DIV) |-> (divisor != '0))
  `ASSERT_CLKD(a_div_ends, clk, rst,
    ((state == B_DIV) && (cnt == CNT_W'(FLOW_W - 1))) |=> (state == B_OUT))
  `ASSERT_CLKD(a_timeout_zero, clk, rst,
    (res_valid && res_job.timed_out) |-> ((res_job.period == '0) && (res_flow == '0)))
  `ASSERT_CLKD(a_zero_period_sat, clk, rst,
    (res_valid && !res_job.timed_out && (res_job.period == '0)) |-> (res_flow == FLOW_SAT))
  `ASSERT_CLKD(a_start_only_start, clk, rst, start_div |-> (state == B_IDLE) && avail)

endmodule

`default_nettype wire

// ===== rtl/pulse_period_flow_meter.sv =====
// ----------------------------------------------------------------------------
// pulse_period_flow_meter - multi-channel pulse period flow meter
// Measures edge-to-edge periods per channel and converts them to 32-bit unsigned flow.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel of arm, edge and tick beats (kind, channel,
//            timestamp). Out-of-range channels and kind 3 are dropped.
//   result : valid/ready channel of result beats (slot, period, flow,
//            timed_out); an edge closing a period, or a timeout tick, yields one beat.
//   cfg    : write port; index 0 is timeout_limit, index 1 flow_constant.
//            Write only while no item is in flight.
// Sequence:
//   The front takes a new item only after the last one is through: accept,
//   then state read-modify-write through the per-channel state RAM, held
//   while a job finds the queue full. Each division result in the back takes
//   a queue pop, 32 quotient steps of the restoring divider, then the output
//   register. Timeout and zero-period results skip the divider: a queue pop,
//   then the output register.
// Reset: every channel reads as armed, registers take their defaults.
// Stall: a held result fills the two-entry job queue; the front then holds
//   the item needing a job, and item.ready stays low until room frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_period_flow_meter
  import ppfm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ppfm_in_if.sink               item,
  ppfm_out_if.source            result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TICK_W-1:0] timeout_limit;
  logic [FLOW_W-1:0] flow_constant;

  // queue hookup
  job_t push_job, pop_job;
  logic push, full, pop, avail;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_LIMIT_RST;
      flow_constant <= FLOW_CONSTANT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[TICK_W-1:0];
        REG_FLOW_CONSTANT: flow_constant <= cfg_data[FLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // classify items, update channel state
  ppfm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .timeout_limit (timeout_limit),
    .job           (push_job),
    .push          (push),
    .full          (full)
  );

  ppfm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .avail    (avail)
  );

  // divide and present results
  ppfm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .avail         (avail),
    .q_job         (pop_job),
    .pop           (pop),
    .flow_constant (flow_constant),
    .result        (result)
  );

endmodule

`default_nettype wire

// ===== dv/tb_pulse_period_flow_meter.sv =====
// ----------------------------------------------------------------------------
// tb_pulse_period_flow_meter - testbench for the pulse period flow meter
// Sends arm, edge and tick beats, predicts every period/flow/timeout beat
// from a per-channel shadow of the meter, and checks the result channel in
// order across several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pulse_period_flow_meter;
  import ppfm_pkg::*;

  localparam int NCH       = CHANNELS_DEF;
  localparam int SETTLE    = 60;    // quiet wait at the end of every drain
  localparam int LONG_HOLD = 400;   // long receiver hold-off, in cycles

  // kind code the block drops; the package only names the live ones
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [STAMP_W-1:0] period;
    logic [FLOW_W-1:0]  flow;
    logic               timed_out;
  } reading_t;

  // Shadow of the meter: per-channel capture state, the two registers and
  // the queue of readings still owed by the block.
  class flow_scoreboard;
    logic [TICK_W-1:0]  limit;
    logic [FLOW_W-1:0]  numer;
    logic [STAMP_W-1:0] stamp [NCH];
    edge_state_t        chan_state [NCH];
    logic [TICK_W-1:0]  ticks [NCH];
    reading_t           owed [$];
    int unsigned        errors;

    function new();
      limit  = TIMEOUT_LIMIT_RST;
      numer  = FLOW_CONSTANT_RST;
      errors = 0;
      for (int i = 0; i < NCH; i++) begin
        stamp[i]      = '0;
        chan_state[i] = EC_WAIT_FIRST;
        ticks[i]      = '0;
      end
    endfunction

    // Called once per accepted item beat.
    function void note_item(logic [KIND_W-1:0] kind, logic [CHAN_W-1:0] chan,
                            logic [STAMP_W-1:0] ts);
      reading_t           r;
      logic [STAMP_W-1:0] span;
      int unsigned        c;
      c = chan;
      if (c >= NCH) return;
      // even channels fill the low slots, odd ones the upper half
      r.slot      = (c % 2 == 0) ? SLOT_W'(c / 2) : SLOT_W'((NCH + 1) / 2 + (c - 1) / 2);
      r.period    = '0;
      r.flow      = '0;
      r.timed_out = 1'b0;
      case (kind)
        KIND_ARM: begin
          chan_state[c] = EC_WAIT_FIRST;
          ticks[c]      = '0;
        end
        KIND_EDGE: begin
          if (chan_state[c] == EC_WAIT_FIRST) begin
            stamp[c]      = ts;
            chan_state[c] = EC_WAIT_SECOND;
          end else if (chan_state[c] == EC_WAIT_SECOND) begin
            span          = ts - stamp[c];   // wraps modulo 2^32
            r.period      = span;
            r.flow        = (span == '0) ? FLOW_SAT : numer / span;
            chan_state[c] = EC_DONE;
            owed.push_back(r);
          end
        end
        KIND_TICK: begin
          if (chan_state[c] != EC_DONE) begin
            if (ticks[c] > limit || ticks[c] == TICK_SAT) begin
              r.timed_out   = 1'b1;
              chan_state[c] = EC_DONE;
              owed.push_back(r);
            end else begin
              ticks[c] = ticks[c] + 1'b1;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Called once per accepted result beat.
    function void check_reading(reading_t got);
      reading_t want;
      if (owed.size() == 0) begin
        $error("result beat with nothing owed: slot %0d period 0x%0h flow 0x%0h",
               got.slot, got.period, got.flow);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("slot", 32'(want.slot), 32'(got.slot));
      compare_field("period", want.period, got.period);
      compare_field("flow", want.flow, got.flow);
      compare_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppfm_in_if  item_ch ();
  ppfm_out_if result_ch ();

  flow_scoreboard sb;

  int unsigned idle_pct   = 0;   // sender: chance of an idle cycle before a beat
  int unsigned stall_pct  = 0;   // receiver: chance of ready low in a cycle
  int unsigned hold_req   = 0;   // bumped by the stimulus to ask for a long hold
  int unsigned hold_ack   = 0;
  int unsigned hold_left  = 0;
  int unsigned beats_sent = 0;   // beats on live kinds and channels

  always #5 clk = ~clk;

  pulse_period_flow_meter #(.CHANNELS(NCH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Receiver: random ready, plus a long hold-off counted here on request.
  // While held, the two-entry job queue fills and item.ready drops.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      result_ch.ready <= 1'b0;
      hold_left       <= LONG_HOLD;
      hold_ack        <= hold_req;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor: every accepted beat is checked against the oldest owed one.
  always @(posedge clk) begin : result_check
    reading_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.slot      = result_ch.slot;
      got.period    = result_ch.period;
      got.flow      = result_ch.flow;
      got.timed_out = result_ch.timed_out;
      sb.check_reading(got);
    end
  end

  // One item beat. Idle cycles go first so valid is never dropped and raised
  // in the same step; the beat is noted in the shadow at the accepting edge.
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [CHAN_W-1:0] chan,
                           input logic [STAMP_W-1:0] ts);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.kind      <= kind;
    item_ch.channel   <= chan;
    item_ch.timestamp <= ts;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(kind, chan, ts);
    if (kind != KIND_UNUSED && chan < NCH) beats_sent++;
  endtask

  // Mostly the next well-formed step of a random channel (arm, first edge,
  // closing edge near the first, ticks), with some raw noise mixed in.
  task automatic random_beat();
    int unsigned        c;
    int unsigned        roll;
    logic [KIND_W-1:0]  kind;
    logic [STAMP_W-1:0] ts;
    logic [STAMP_W-1:0] delta;
    roll = $urandom_range(99);
    c    = $urandom_range(NCH - 1);
    ts   = $urandom();
    case ($urandom_range(3))
      0:       delta = $urandom_range(3);        // zero period now and then
      1:       delta = $urandom_range(4095);
      2:       delta = $urandom_range(1 << 20);
      default: delta = $urandom();
    endcase
    if (roll < 10) begin
      // noise: any kind code, any channel code
      kind = KIND_W'($urandom_range(2 ** KIND_W - 1));
      c    = $urandom_range(2 ** CHAN_W - 1);
    end else begin
      case (sb.chan_state[c])
        EC_DONE:       kind = (roll < 85) ? KIND_ARM : ((roll < 93) ? KIND_EDGE : KIND_TICK);
        EC_WAIT_FIRST: kind = (roll < 75) ? KIND_EDGE : KIND_TICK;
        default: begin
          kind = (roll < 65) ? KIND_EDGE : ((roll < 95) ? KIND_TICK : KIND_ARM);
          ts   = sb.stamp[c] + delta;
        end
      endcase
    end
    send_beat(kind, CHAN_W'(c), ts);
  endtask

  task automatic run_items(input int unsigned count);
    int unsigned stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) random_beat();
  endtask

  // Sender goes quiet until every owed reading is in, then lets the block
  // finish any beat that owes nothing.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  task automatic set_regs(input logic [TICK_W-1:0] limit, input logic [FLOW_W-1:0] numer);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TIMEOUT_LIMIT;
    cfg_data  <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_index <= REG_FLOW_CONSTANT;
    cfg_data  <= numer;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    sb.limit = limit;
    sb.numer = numer;
  endtask

  initial begin
    sb                = new();
    item_ch.valid     = 1'b0;
    item_ch.kind      = KIND_ARM;
    item_ch.channel   = '0;
    item_ch.timestamp = '0;
    result_ch.ready   = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_TIMEOUT_LIMIT;
    cfg_data          = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed, reset register values ----
    send_beat(KIND_EDGE, 4'd0, 32'h0000_0000);
    send_beat(KIND_EDGE, 4'd0, 32'hffff_ffff);     // largest period, flow 0
    send_beat(KIND_EDGE, 4'd1, 32'hffff_ffff);
    send_beat(KIND_EDGE, 4'd1, 32'h0000_0000);     // counter wrap, period 1
    send_beat(KIND_EDGE, 4'd2, 32'h1234_5678);
    send_beat(KIND_EDGE, 4'd2, 32'h1234_5678);     // zero period, flow saturates
    send_beat(KIND_EDGE, 4'd2, 32'h0000_0005);     // done channel: dropped
    send_beat(KIND_TICK, 4'd2, 32'h0000_0000);     // done channel: dropped
    send_beat(KIND_ARM,  4'd2, 32'h0000_0000);
    send_beat(KIND_EDGE, 4'd2, 32'h8000_0000);
    send_beat(KIND_EDGE, 4'd2, 32'h8000_1000);
    send_beat(KIND_EDGE, 4'd11, 32'ha5a5_a5a5);
    send_beat(KIND_EDGE, 4'd11, 32'h5a5a_5a5a);    // top odd channel, top slot
    send_beat(KIND_UNUSED, 4'd3, 32'hffff_ffff);   // unused kind: dropped
    send_beat(KIND_EDGE, 4'd12, 32'h0000_0000);    // channel past the last one
    send_beat(KIND_ARM,  4'd15, 32'hffff_ffff);
    send_beat(KIND_UNUSED, 4'd15, 32'h0000_0000);
    send_beat(KIND_EDGE, 4'd10, 32'h0000_0000);
    send_beat(KIND_TICK, 4'd10, 32'h0000_0000);
    send_beat(KIND_EDGE, 4'd10, 32'h0001_0000);
    drain();

    // ---- zero timeout limit, largest constant ----
    set_regs(8'd0, 32'hffff_ffff);
    send_beat(KIND_ARM,  4'd4, 32'h0000_0000);
    send_beat(KIND_TICK, 4'd4, 32'h0000_0000);
    send_beat(KIND_TICK, 4'd4, 32'h0000_0000);     // second tick times out
    send_beat(KIND_TICK, 4'd4, 32'h0000_0000);
    send_beat(KIND_EDGE, 4'd4, 32'h0000_0064);
    send_beat(KIND_ARM,  4'd4, 32'h0000_0000);
    send_beat(KIND_EDGE, 4'd4, 32'h0000_0064);
    send_beat(KIND_EDGE, 4'd4, 32'h0000_0065);

    // random, no idling either side; a long receiver hold midway
    run_items(80);
    hold_req <= hold_req + 1;
    run_items(100);
    drain();

    // ---- largest limit, smallest constant, sender idles ----
    set_regs(8'd255, 32'd1);
    // tick counter saturates: 255 counted, the next one times out
    send_beat(KIND_ARM, 4'd7, 32'h0000_0000);
    repeat (257) send_beat(KIND_TICK, 4'd7, 32'h0000_0000);
    idle_pct = 76;
    run_items(200);
    drain();

    // ---- short limit, random constant, receiver stalls ----
    idle_pct  = 0;
    stall_pct = 76;
    set_regs(TICK_W'($urandom_range(1, 8)), $urandom() | 32'h1);
    run_items(100);
    drain();                                       // sender waits for every reading
    run_items(100);
    drain();

    // ---- random settings, both sides idle ----
    idle_pct  = 29;
    stall_pct = 29;
    set_regs(TICK_W'($urandom_range(0, 40)), $urandom() | 32'h1);
    run_items(200);
    drain();

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
